>>> hdl/oes_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oes_pkg: shared types and constants of the overlap epoch scheduler
// Holds the geometry of one stored scope, field widths and the FSM states.
// ----------------------------------------------------------------------------
package oes_pkg;

  localparam int unsigned MaxScopes = 64;
  localparam int unsigned CoordBits = 16;
  localparam int unsigned AddrW     = $clog2(MaxScopes);
  localparam int unsigned CountW    = $clog2(MaxScopes + 1);
  localparam int unsigned EpochW    = 6;
  localparam int unsigned EdgeW     = 11;
  localparam int unsigned BarrierW  = 6;
  localparam int unsigned TagW      = 32;

  // Input word: eight rectangle edges followed by the scene tag.
  localparam int unsigned InDataW   = 8 * CoordBits + TagW;
  // Output word: epoch, edge total, barrier total, padded to whole bytes.
  localparam int unsigned OutRawW   = EpochW + EdgeW + BarrierW;
  localparam int unsigned OutDataW  = ((OutRawW + 7) / 8) * 8;

  typedef logic signed [CoordBits-1:0] coord_t;
  typedef logic [EpochW-1:0]           epoch_t;
  typedef logic [EdgeW-1:0]            edge_cnt_t;
  typedef logic [BarrierW-1:0]         barrier_cnt_t;
  typedef logic [TagW-1:0]             tag_t;
  typedef logic [CountW-1:0]           count_t;

  localparam epoch_t       EpochMax   = '1;
  localparam edge_cnt_t    EdgeMax    = '1;
  localparam barrier_cnt_t BarrierMax = '1;

  typedef struct packed {
    coord_t left;
    coord_t top;
    coord_t right;
    coord_t bottom;
  } rect_t;

  typedef struct packed {
    rect_t  wr_rect;
    rect_t  rd_rect;
    epoch_t epoch;
  } entry_t;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StFinish
  } state_e;

endpackage

>>> hdl/oes_scope_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oes_scope_ram: simple dual-port scope store
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module oes_scope_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

>>> hdl/oes_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oes_match: dependency test of one stored scope against the new scope
// A stored write area that meets the new read or write area, or a stored
// read area that meets the new write area, makes a dependency.
// ----------------------------------------------------------------------------
module oes_match (
  input  oes_pkg::entry_t stored_i,
  input  oes_pkg::rect_t  wr_rect_i,
  input  oes_pkg::rect_t  rd_rect_i,
  output logic            dep_o
);
  import oes_pkg::*;

  // Strict intersection; an empty rectangle never meets anything.
  function automatic logic rect_meet(rect_t a, rect_t b);
    logic a_full;
    logic b_full;
    a_full = (a.left < a.right) && (a.top < a.bottom);
    b_full = (b.left < b.right) && (b.top < b.bottom);
    return a_full && b_full &&
           (a.left < b.right) && (b.left < a.right) &&
           (a.top < b.bottom) && (b.top < a.bottom);
  endfunction

  assign dep_o = rect_meet(stored_i.wr_rect, rd_rect_i) ||
                 rect_meet(stored_i.wr_rect, wr_rect_i) ||
                 rect_meet(stored_i.rd_rect, wr_rect_i);

endmodule

>>> hdl/overlap_epoch_scheduler_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// overlap_epoch_scheduler_top: epoch assignment for overlapping render scopes
// Stores the scopes of a plan and gives each new scope its dependency epoch.
// ----------------------------------------------------------------------------
// Each input word is one render scope. The block keeps every scope of the
// current plan in an on-chip store of 64 entries and walks that store, one
// entry per clock through the read port of the memory, to find earlier
// scopes whose areas conflict with the new one. A scope that is compared
// against N stored scopes (N from 1 to 64) goes through these steps: the
// word is taken, the N stored entries are read, the last entry is compared,
// and the scope is stored while the result register is loaded. Only then
// is the next scope accepted. A scope that starts a plan, or that finds the
// store empty, skips the scan. The result register sits between the two
// sides, so a new scope is taken while the previous result still waits
// downstream; the store-and-load step of that new scope then waits until
// the previous result word is taken. A set first_of_plan flag empties the
// store at once; the store needs no clearing pass after reset because only
// entries below the scope count are ever read. Once the store is full,
// later scopes of the same plan are still scheduled against it but are not
// stored, and their result carries the overflow flag.
// ----------------------------------------------------------------------------
module overlap_epoch_scheduler_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Scope input.
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // tdata from bit 0: write_left, write_top, write_right, write_bottom,
  // read_left, read_top, read_right, read_bottom (16 each), scene_tag (32).
  input  logic [oes_pkg::InDataW-1:0]   s_axis_tdata_i,
  // tuser: first_of_plan.
  input  logic                          s_axis_tuser_i,
  // Result output.
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // tdata from bit 0: epoch (6), edge_total (11), barrier_total (6), one zero.
  output logic [oes_pkg::OutDataW-1:0]  m_axis_tdata_o,
  // tuser: overflow.
  output logic                          m_axis_tuser_o
);
  import oes_pkg::*;

  // Unpacked view of the incoming word.
  rect_t in_wr;
  rect_t in_rd;
  tag_t  in_tag;

  assign in_wr.left   = coord_t'(s_axis_tdata_i[0*CoordBits +: CoordBits]);
  assign in_wr.top    = coord_t'(s_axis_tdata_i[1*CoordBits +: CoordBits]);
  assign in_wr.right  = coord_t'(s_axis_tdata_i[2*CoordBits +: CoordBits]);
  assign in_wr.bottom = coord_t'(s_axis_tdata_i[3*CoordBits +: CoordBits]);
  assign in_rd.left   = coord_t'(s_axis_tdata_i[4*CoordBits +: CoordBits]);
  assign in_rd.top    = coord_t'(s_axis_tdata_i[5*CoordBits +: CoordBits]);
  assign in_rd.right  = coord_t'(s_axis_tdata_i[6*CoordBits +: CoordBits]);
  assign in_rd.bottom = coord_t'(s_axis_tdata_i[7*CoordBits +: CoordBits]);
  assign in_tag       = s_axis_tdata_i[8*CoordBits +: TagW];

  // Control and plan state.
  state_e       state_q, state_d;
  count_t       count_q, count_d;
  count_t       rd_idx_q, rd_idx_d;
  logic         cmp_vld_q, cmp_vld_d;
  tag_t         prev_tag_q, prev_tag_d;
  epoch_t       floor_q, floor_d;
  epoch_t       highest_q, highest_d;
  epoch_t       epoch_q, epoch_d;
  edge_cnt_t    edge_q, edge_d;
  barrier_cnt_t barrier_q, barrier_d;
  logic         m_valid_q, m_valid_d;

  // Payload of the scope under work and of the result register.
  rect_t                wr_q, wr_d;
  rect_t                rd_q, rd_d;
  tag_t                 tag_q, tag_d;
  logic [OutDataW-1:0]  m_data_q, m_data_d;
  logic                 m_ovf_q, m_ovf_d;

  // Store interface.
  logic                 ram_we;
  logic [$bits(entry_t)-1:0] ram_rdata;
  entry_t               stored;
  entry_t               new_entry;
  logic                 dep;
  epoch_t               stored_next;

  logic   issuing;
  logic   full;
  logic   out_free;

  assign issuing  = rd_idx_q < count_q;
  assign full     = count_q == CountW'(MaxScopes);
  assign out_free = !m_valid_q || m_axis_tready_i;

  assign new_entry = '{wr_rect: wr_q, rd_rect: rd_q, epoch: epoch_q};
  assign stored    = entry_t'(ram_rdata);

  oes_scope_ram #(
    .Width ($bits(entry_t)),
    .Depth (MaxScopes)
  ) u_scope_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[AddrW-1:0]),
    .wdata_i (new_entry),
    .raddr_i (rd_idx_q[AddrW-1:0]),
    .rdata_o (ram_rdata)
  );

  oes_match u_match (
    .stored_i  (stored),
    .wr_rect_i (wr_q),
    .rd_rect_i (rd_q),
    .dep_o     (dep)
  );

  assign stored_next = (stored.epoch == EpochMax) ? EpochMax : stored.epoch + 1'b1;

  always_comb begin
    epoch_t floor_nx;

    state_d    = state_q;
    count_d    = count_q;
    rd_idx_d   = rd_idx_q;
    prev_tag_d = prev_tag_q;
    floor_d    = floor_q;
    highest_d  = highest_q;
    epoch_d    = epoch_q;
    edge_d     = edge_q;
    barrier_d  = barrier_q;
    wr_d       = wr_q;
    rd_d       = rd_q;
    tag_d      = tag_q;
    m_data_d   = m_data_q;
    m_ovf_d    = m_ovf_q;
    ram_we     = 1'b0;
    floor_nx   = floor_q;

    m_valid_d = m_valid_q && !m_axis_tready_i;
    cmp_vld_d = (state_q == StScan) && issuing;

    case (state_q)
      StIdle: begin
        if (s_axis_tvalid_i) begin
          wr_d     = in_wr;
          rd_d     = in_rd;
          tag_d    = in_tag;
          rd_idx_d = '0;
          if (s_axis_tuser_i) begin
            // New plan: forget the store and all running counts.
            count_d   = '0;
            floor_d   = '0;
            highest_d = '0;
            edge_d    = '0;
            barrier_d = '0;
            epoch_d   = '0;
            state_d   = StFinish;
          end else begin
            if ((count_q != '0) && (in_tag != prev_tag_q)) begin
              // Scene change: everything so far must finish first.
              floor_nx  = (highest_q == EpochMax) ? EpochMax : highest_q + 1'b1;
              floor_d   = floor_nx;
              barrier_d = (barrier_q == BarrierMax) ? BarrierMax : barrier_q + 1'b1;
            end
            epoch_d = floor_nx;
            state_d = (count_q != '0) ? StScan : StFinish;
          end
        end
      end
      StScan: begin
        // The compare of the last entry lands on the same edge as the exit.
        if (issuing) begin
          rd_idx_d = rd_idx_q + 1'b1;
        end else begin
          state_d = StFinish;
        end
      end
      StFinish: begin
        if (out_free) begin
          ram_we     = !full;
          count_d    = full ? count_q : count_q + 1'b1;
          highest_d  = (epoch_q > highest_q) ? epoch_q : highest_q;
          prev_tag_d = tag_q;
          m_valid_d  = 1'b1;
          m_data_d   = OutDataW'({barrier_q, edge_q, epoch_q});
          m_ovf_d    = full;
          state_d    = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    // Compare stage, in the cycle after the read address.
    if (cmp_vld_q && dep) begin
      edge_d = (edge_q == EdgeMax) ? EdgeMax : edge_q + 1'b1;
      if (stored_next > epoch_q) begin
        epoch_d = stored_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      count_q    <= '0;
      rd_idx_q   <= '0;
      cmp_vld_q  <= 1'b0;
      prev_tag_q <= '0;
      floor_q    <= '0;
      highest_q  <= '0;
      epoch_q    <= '0;
      edge_q     <= '0;
      barrier_q  <= '0;
      m_valid_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      rd_idx_q   <= rd_idx_d;
      cmp_vld_q  <= cmp_vld_d;
      prev_tag_q <= prev_tag_d;
      floor_q    <= floor_d;
      highest_q  <= highest_d;
      epoch_q    <= epoch_d;
      edge_q     <= edge_d;
      barrier_q  <= barrier_d;
      m_valid_q  <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wr_q     <= wr_d;
    rd_q     <= rd_d;
    tag_q    <= tag_d;
    m_data_q <= m_data_d;
    m_ovf_q  <= m_ovf_d;
  end

  assign s_axis_tready_o = state_q == StIdle;
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_ovf_q;

  // The store is never written while a scan may still read it.
  a_no_write_during_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == StFinish) && !cmp_vld_q)
    else $error("scope store written during a scan");

  // The read index never runs past the stored scope count.
  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StScan) |-> (rd_idx_q <= count_q))
    else $error("scan index beyond scope count");

  // A finished scope never gets an epoch below the floor.
  a_epoch_above_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StFinish) |-> (epoch_q >= floor_q))
    else $error("epoch below floor");

  // The count of stored scopes stays within the store.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(MaxScopes))
    else $error("scope count beyond capacity");

endmodule
